>>> hdl/lwts_pkg.sv
// ----------------------------------------------------------------------------
// lwts_pkg: shared constants and types
// Sizes of the window store, the running sum and the result fields of the
// longest window with target sum block.
// ----------------------------------------------------------------------------
package lwts_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int VALUE_BITS   = 16;

    localparam int ELEM_BITS    = 16;
    localparam int TARGET_BITS  = 26;
    localparam int LEN_BITS     = 11;
    localparam int IDX_BITS     = $clog2(WINDOW_DEPTH);
    localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
    // the sum stays at or below the target between items; one element on top
    localparam int SUM_BITS     = TARGET_BITS + 1;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_TARGET_SUM = 1'b0;

    typedef struct packed {
        logic [LEN_BITS-1:0] best_length;
        logic                window_overflow;
        logic                array_done;
    } t_result;

endpackage

>>> hdl/longest_window_with_target_sum_core.sv
// ----------------------------------------------------------------------------
// longest_window_with_target_sum_core: longest window with target sum
// Sliding window over non-negative elements; reports the longest window
// whose sum equals the programmed target.
//
// Input channel: i_in_valid / o_in_stall carry one element per transfer,
//   with i_last_element marking the end of an array.
// Output channel: o_out_valid / i_out_stall carry one result per element:
//   best length so far, overflow flag, and the echoed last flag.
// Sequence: an accepted element passes through S_DROP (only when the store
//   is full, to drop the oldest element), S_ADD and S_SHRINK, which drops
//   elements from the oldest end while the sum is above the target; the
//   result is then registered. The single sum adder and the one read port
//   of the window RAM set this order; each element is dropped once.
// The input is stalled while an element is in work. A result waiting in the
//   output register does not block the next input; the engine holds its
//   last step until that register is free.
// Reset clears the window, best length, target (0) and output valid. The
//   window RAM needs no clearing. pready is always high. The user writes
//   target_sum over APB at address 0 only when idle; the block does not check.
// ----------------------------------------------------------------------------
module longest_window_with_target_sum_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lwts_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lwts_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lwts_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lwts_pkg::ELEM_BITS-1:0]      i_element_value,
    input  logic                                i_last_element,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lwts_pkg::LEN_BITS-1:0]       o_best_length,
    output logic                                o_window_overflow,
    output logic                                o_array_done
);

    logic [lwts_pkg::TARGET_BITS-1:0] r_target_sum;
    logic                             reg_index;
    logic                             cfg_write;
    lwts_pkg::t_result                result;
    logic                             wr_en;
    logic [lwts_pkg::IDX_BITS-1:0]    wr_addr;
    logic [lwts_pkg::VALUE_BITS-1:0]  wr_data;
    logic [lwts_pkg::IDX_BITS-1:0]    rd_addr;
    logic [lwts_pkg::VALUE_BITS-1:0]  rd_data;

    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_sum <= '0;
        end else if (cfg_write && (reg_index == lwts_pkg::REG_TARGET_SUM)) begin
            r_target_sum <= pwdata[lwts_pkg::TARGET_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == lwts_pkg::REG_TARGET_SUM) begin
            prdata = lwts_pkg::APB_DATA_BITS'(r_target_sum);
        end
    end

    lwts_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_target_sum    (r_target_sum),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_element_value (i_element_value),
        .i_last_element  (i_last_element),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result        (result),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data)
    );

    lwts_ram #(
        .WIDTH (lwts_pkg::VALUE_BITS),
        .DEPTH (lwts_pkg::WINDOW_DEPTH)
    ) u_window_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_best_length     = result.best_length;
    assign o_window_overflow = result.window_overflow;
    assign o_array_done      = result.array_done;

endmodule

>>> hdl/lwts_ram.sv
// ----------------------------------------------------------------------------
// lwts_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lwts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/lwts_engine.sv
// ----------------------------------------------------------------------------
// lwts_engine: window sequencer and shared sum unit
// Appends each element to the circular window, shrinks the window from the
// oldest end one element a cycle through a single add/subtract unit, and
// keeps the longest length whose sum matches the target.
// ----------------------------------------------------------------------------
module lwts_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lwts_pkg::TARGET_BITS-1:0] i_target_sum,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [lwts_pkg::ELEM_BITS-1:0]   i_element_value,
    input  logic                            i_last_element,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lwts_pkg::t_result               o_result,
    output logic                            o_wr_en,
    output logic [lwts_pkg::IDX_BITS-1:0]    o_wr_addr,
    output logic [lwts_pkg::VALUE_BITS-1:0]  o_wr_data,
    output logic [lwts_pkg::IDX_BITS-1:0]    o_rd_addr,
    input  logic [lwts_pkg::VALUE_BITS-1:0]  i_rd_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DROP   = 2'd1;
    localparam logic [1:0] S_ADD    = 2'd2;
    localparam logic [1:0] S_SHRINK = 2'd3;

    localparam logic [lwts_pkg::IDX_BITS-1:0] IDX_LAST =
        lwts_pkg::IDX_BITS'(lwts_pkg::WINDOW_DEPTH - 1);
    localparam logic [lwts_pkg::CNT_BITS-1:0] CNT_FULL =
        lwts_pkg::CNT_BITS'(lwts_pkg::WINDOW_DEPTH);
    localparam logic [lwts_pkg::CNT_BITS-1:0] CNT_ONE =
        lwts_pkg::CNT_BITS'(1);

    function automatic logic [lwts_pkg::IDX_BITS-1:0] next_idx(
        input logic [lwts_pkg::IDX_BITS-1:0] idx
    );
        return (idx == IDX_LAST) ? '0 : idx + lwts_pkg::IDX_BITS'(1);
    endfunction

    logic [1:0]                          r_state,  n_state;
    logic [lwts_pkg::SUM_BITS-1:0]       r_sum,    n_sum;
    logic [lwts_pkg::IDX_BITS-1:0]       r_head,   n_head;
    logic [lwts_pkg::IDX_BITS-1:0]       r_tail,   n_tail;
    logic [lwts_pkg::CNT_BITS-1:0]       r_count,  n_count;
    logic [lwts_pkg::CNT_BITS-1:0]       r_best,   n_best;
    logic [lwts_pkg::VALUE_BITS-1:0]     r_value,  n_value;
    logic                                r_last,   n_last;
    logic                                r_ovf,    n_ovf;
    logic                                r_out_valid, n_out_valid;
    lwts_pkg::t_result                   r_out,    n_out;

    logic                                unit_sub;
    logic [lwts_pkg::SUM_BITS-1:0]       unit_b;
    logic [lwts_pkg::SUM_BITS-1:0]       unit_res;
    logic [lwts_pkg::SUM_BITS-1:0]       target_ext;
    logic                                sum_gt;
    logic                                sum_eq;
    logic                                out_free;
    logic                                wr_en;

    // shared add/subtract unit on the running sum
    assign unit_res   = unit_sub ? (r_sum - unit_b) : (r_sum + unit_b);
    assign target_ext = {1'b0, i_target_sum};
    assign sum_gt     = r_sum > target_ext;
    assign sum_eq     = r_sum == target_ext;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_best      = r_best;
        n_value     = r_value;
        n_last      = r_last;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unit_sub    = 1'b1;
        unit_b      = lwts_pkg::SUM_BITS'(i_rd_data);
        wr_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value = i_element_value[lwts_pkg::VALUE_BITS-1:0];
                    n_last  = i_last_element;
                    n_ovf   = (r_count == CNT_FULL);
                    n_state = (r_count == CNT_FULL) ? S_DROP : S_ADD;
                end
            end
            S_DROP: begin
                n_sum   = unit_res;
                n_head  = next_idx(r_head);
                n_count = r_count - CNT_ONE;
                n_state = S_ADD;
            end
            S_ADD: begin
                unit_sub = 1'b0;
                unit_b   = lwts_pkg::SUM_BITS'(r_value);
                n_sum    = unit_res;
                wr_en    = 1'b1;
                n_tail   = next_idx(r_tail);
                n_count  = r_count + CNT_ONE;
                n_state  = S_SHRINK;
            end
            S_SHRINK: begin
                if (sum_gt && (r_count != '0)) begin
                    // the lone element may be the one just written: no read
                    n_sum   = (r_count == CNT_ONE) ? '0 : unit_res;
                    n_head  = next_idx(r_head);
                    n_count = r_count - CNT_ONE;
                end else if (out_free) begin
                    n_best = (sum_eq && (r_count > r_best)) ? r_count : r_best;
                    n_out_valid           = 1'b1;
                    n_out.best_length     = lwts_pkg::LEN_BITS'(n_best);
                    n_out.window_overflow = r_ovf;
                    n_out.array_done      = r_last;
                    if (r_last) begin
                        n_sum   = '0;
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                        n_best  = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_last  <= n_last;
        r_ovf   <= n_ovf;
        r_out   <= n_out;
    end

    // read address follows the next head so the registered read returns the oldest element
    assign o_rd_addr   = n_head;
    assign o_wr_en     = wr_en;
    assign o_wr_addr   = r_tail;
    assign o_wr_data   = r_value;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
